### sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/iwcu_pkg.sv
package iwcu_pkg;
  localparam int unsigned Side = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegBondThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] RegRngSeed = 1'd1;
  localparam int unsigned ThrW = 17;

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StSeedR = 12'b000000000010,
    StSeedW = 12'b000000000100,
    StPop   = 12'b000000001000,
    StNbRd  = 12'b000000010000,
    StNbChk = 12'b000000100000,
    StClear = 12'b000001000000,
    StSumRd = 12'b000010000000,
    StSumAc = 12'b000100000000,
    StOut   = 12'b001000000000,
    StWait  = 12'b010000000000,
    StInit  = 12'b100000000000
  } state_e;

  function automatic logic [31:0] xorshift32(logic [31:0] x);
    logic [31:0] a, b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction
endpackage

### sv/ising_wolff_cluster_update_top.sv
// Wolff cluster update on a periodic SIDE x SIDE lattice of one-bit spins.
// Each beat on s_axis names a seed site; one result beat follows on m_axis.
// For a cluster of C sites the update runs from the seed beat until the result
// beat is offered in these steps: a read and a flip of the seed; for each cluster
// site a pop, a queue read, then a read and a check for each of the four
// neighbours through one read port of the spin and mark memories; one last pop;
// a clear of the marks by a sweep of the cluster queue; and an energy pass of a
// read and an accumulate per site, which reads three spins per site from a
// three-bank lattice copy. After reset a clearing pass sets every spin to +1
// and every mark to zero before the first seed is taken.
// The block accepts no seed while an update is in flight.
module ising_wolff_cluster_update_top import iwcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // seed_row[5:0], seed_col[11:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // cluster_size[12:0], spin_sum[26:13], energy_sum[41:27]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
`include "assert_macros.svh"
  localparam int unsigned CW = $clog2(Side);
  localparam int unsigned SITES = Side * Side;
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned NW = AW + 1;

  state_e st_q, st_d;
  logic [ThrW-1:0] thr_q;
  // spin copies: 0 base, 1/2 mirrors for energy pass; all hold inverted spin
  logic flip0 [SITES];
  logic flip1 [SITES];
  logic flip2 [SITES];
  logic mark  [SITES];
  logic [AW-1:0] queue [SITES];
  logic [AW-1:0] seed_q, cur_q, nb_q, sweep_q, init_q;
  logic [NW-1:0] head_q, tail_q, cnt_q;
  logic [1:0] dir_q;
  logic s_q;
  logic rd_flip_q, rd_mark_q, rd_a_q, rd_b_q, rd_c_q;
  logic [AW-1:0] qrd_q;
  logic signed [15:0] ssum_q, esum_q;
  logic [41:0] res_q;
  logic [AW-1:0] rd_addr, wr_addr, qa, qb, qc;
  logic wr_en, wr_val, mk_en, mk_val, q_we, rng_step;
  logic [15:0] draw;
  logic [AW-1:0] cur_src;
  logic [CW-1:0] r, c;
  logic [AW-1:0] nbr;
  logic spin_rd, mark_rd, sa, sb, sc;

  assign cfg_ready_o = (st_q == StIdle);
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata = {6'd0, res_q};

  iwcu_rng u_rng (
    .clk_i, .rst_ni,
    .load_i(cfg_valid_i && cfg_ready_o && cfg_index_i == RegRngSeed),
    .seed_i(cfg_data_i), .step_i(rng_step), .draw_o(draw)
  );

  assign spin_rd = ~rd_flip_q;
  assign mark_rd = rd_mark_q;
  assign sa = ~rd_a_q;
  assign sb = ~rd_b_q;
  assign sc = ~rd_c_q;

  // the popped site arrives from the queue read while in StWait
  assign cur_src = (st_q == StWait) ? qrd_q : cur_q;
  assign r = cur_src[AW-1:CW];
  assign c = cur_src[CW-1:0];
  always_comb begin
    case (dir_q)
      2'd0: nbr = {r, CW'((c == CW'(Side-1)) ? '0 : c + 1'b1)};
      2'd1: nbr = {r, CW'((c == '0) ? CW'(Side-1) : c - 1'b1)};
      2'd2: nbr = {CW'((r == CW'(Side-1)) ? '0 : r + 1'b1), c};
      default: nbr = {CW'((r == '0) ? CW'(Side-1) : r - 1'b1), c};
    endcase
  end
  // energy pass neighbours of sweep site
  assign qa = sweep_q;
  assign qb = {sweep_q[AW-1:CW],
               CW'((sweep_q[CW-1:0] == CW'(Side-1)) ? '0 : sweep_q[CW-1:0] + 1'b1)};
  assign qc = {CW'((sweep_q[AW-1:CW] == CW'(Side-1)) ? '0 : sweep_q[AW-1:CW] + 1'b1),
               sweep_q[CW-1:0]};

  logic joins;
  assign joins = ({1'b0, draw} < thr_q);

  always_comb begin
    st_d = st_q; wr_en = 1'b0; wr_val = 1'b0; wr_addr = seed_q;
    mk_en = 1'b0; mk_val = 1'b0; q_we = 1'b0; rng_step = 1'b0;
    rd_addr = nb_q;
    case (st_q)
      StInit: begin
        wr_addr = init_q; wr_en = 1'b1; wr_val = 1'b1; mk_en = 1'b1; mk_val = 1'b0;
        if (init_q == AW'(SITES-1)) st_d = StIdle;
      end
      StIdle:  if (s_axis_tvalid) st_d = StSeedR;
      StSeedR: begin rd_addr = seed_q; st_d = StSeedW; end
      StSeedW: begin
        wr_en = 1'b1; wr_val = ~spin_rd; mk_en = 1'b1; mk_val = 1'b1; q_we = 1'b1;
        st_d = StPop;
      end
      StPop:   st_d = (head_q == tail_q) ? StClear : StWait;
      StWait:  st_d = StNbRd;
      StNbRd:  begin rd_addr = nb_q; st_d = StNbChk; end
      StNbChk: begin
        wr_addr = nb_q;
        if (spin_rd == s_q && !mark_rd) begin
          rng_step = 1'b1;
          if (joins && tail_q < NW'(SITES)) begin
            wr_en = 1'b1; wr_val = ~s_q; mk_en = 1'b1; mk_val = 1'b1; q_we = 1'b1;
          end
        end
        st_d = (dir_q == 2'd3) ? StPop : StNbRd;
      end
      StClear: begin
        wr_addr = qrd_q;
        if (cnt_q != '0) begin mk_en = 1'b1; mk_val = 1'b0; end
        if (cnt_q == tail_q) st_d = StSumRd;
      end
      StSumRd: st_d = StSumAc;
      StSumAc: st_d = (sweep_q == AW'(SITES-1)) ? StOut : StSumRd;
      StOut:   if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // stored bit is inverted spin; the pass after reset writes it to zero
  always_ff @(posedge clk_i) begin
    rd_flip_q <= flip0[rd_addr];
    rd_mark_q <= mark[rd_addr];
    rd_a_q <= flip0[qa];
    rd_b_q <= flip1[qb];
    rd_c_q <= flip2[qc];
    qrd_q <= queue[(st_q == StClear) ? cnt_q[AW-1:0] : head_q[AW-1:0]];
    if (wr_en) begin
      flip0[wr_addr] <= ~wr_val;
      flip1[wr_addr] <= ~wr_val;
      flip2[wr_addr] <= ~wr_val;
    end
    if (mk_en) mark[wr_addr] <= mk_val;
    if (q_we) queue[tail_q[AW-1:0]] <= wr_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; thr_q <= '0; init_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == RegBondThreshold)
        thr_q <= cfg_data_i[ThrW-1:0];
      if (st_q == StInit) init_q <= init_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        seed_q <= {CW'(s_axis_tdata[5:0] % Side), CW'(s_axis_tdata[11:6] % Side)};
        head_q <= '0; tail_q <= '0; cnt_q <= '0; sweep_q <= '0;
        ssum_q <= '0; esum_q <= '0;
      end
      StSeedW: begin s_q <= spin_rd; tail_q <= tail_q + 1'b1; end
      StPop: dir_q <= 2'd0;
      StWait: begin cur_q <= qrd_q; head_q <= head_q + 1'b1; nb_q <= nbr; end
      StNbChk: begin
        if (spin_rd == s_q && !mark_rd && joins && tail_q < NW'(SITES)) tail_q <= tail_q + 1'b1;
        dir_q <= dir_q + 1'b1;
        nb_q <= (dir_q == 2'd0) ? {r, CW'((c == '0) ? CW'(Side-1) : c - 1'b1)} :
                (dir_q == 2'd1) ? {CW'((r == CW'(Side-1)) ? '0 : r + 1'b1), c} :
                {CW'((r == '0) ? CW'(Side-1) : r - 1'b1), c};
      end
      StClear: cnt_q <= cnt_q + 1'b1;
      StSumAc: begin
        ssum_q <= ssum_q + (sa ? 16'sd1 : -16'sd1);
        esum_q <= esum_q - ((sa == sb) ? 16'sd1 : -16'sd1) - ((sa == sc) ? 16'sd1 : -16'sd1);
        sweep_q <= sweep_q + 1'b1;
        if (sweep_q == AW'(SITES-1))
          res_q <= {esum_q[14:0] - 15'((sa == sb) ? 1 : -1) - 15'((sa == sc) ? 1 : -1),
                    ssum_q[13:0] + 14'(sa ? 1 : -1), tail_q[12:0]};
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_busy_not_ready, st_q != StIdle, !s_axis_tready)
  `ASSERT_IMPL(a_head_le_tail, st_q == StPop, head_q <= tail_q)
  `ASSERT_NEXT(a_out_after_sum, st_q == StSumAc && sweep_q == AW'(SITES-1), st_q == StOut)
endmodule

### sv/iwcu_rng.sv
module iwcu_rng import iwcu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] seed_i,
  input  logic        step_i,
  output logic [15:0] draw_o
);
  logic [31:0] state_q, state_d, nxt;
  assign nxt = xorshift32(state_q);
  assign draw_o = nxt[31:16];
  always_comb begin
    state_d = state_q;
    if (load_i) begin
      state_d = (seed_i == 32'd0) ? 32'd1 : seed_i;
    end else if (step_i) begin
      state_d = nxt;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 32'd1;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### tb/tb_ising_wolff_cluster_update_top.sv
module tb_ising_wolff_cluster_update_top import iwcu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Sites = Side * Side;

  typedef struct packed {
    logic [14:0] energy_sum;
    logic [13:0] spin_sum;
    logic [12:0] cluster_size;
  } flip_result_t;

  typedef enum logic [1:0] {RowSeed, RowReg, RowPause} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [0:0]   reg_idx;
    logic [31:0]  reg_val;
    logic [5:0]   row;
    logic [5:0]   col;
    bit           typed;
    flip_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  ising_wolff_cluster_update_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Shadow lattice and generator
  bit          spin_sh [Sites];
  bit          mark_sh [Sites];
  int unsigned walk_q  [Sites];
  logic [31:0] rng_sh;
  logic [16:0] thr_sh;

  flip_result_t pending_flips[$];
  bit           typed_q[$];
  flip_result_t typed_want_q[$];
  int unsigned  mismatches;
  int unsigned  tx_idle;
  int unsigned  rx_idle;
  int unsigned  hold_cycles;

  function automatic logic [15:0] draw_bond();
    logic [31:0] x;
    x = rng_sh;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng_sh = x;
    return x[31:16];
  endfunction

  function automatic flip_result_t flip_cluster(logic [5:0] row, logic [5:0] col);
    int unsigned head, tail, cur, r, c, t, k;
    int unsigned nb[4];
    bit s;
    int ssum, esum;
    flip_result_t res;
    head = 0;
    tail = 0;
    cur = row * Side + col;
    s = spin_sh[cur];
    spin_sh[cur] = ~s;
    mark_sh[cur] = 1'b1;
    walk_q[tail++] = cur;
    while (head < tail) begin
      cur = walk_q[head++];
      r = cur / Side;
      c = cur % Side;
      nb[0] = r * Side + (c + 1) % Side;
      nb[1] = r * Side + (c + Side - 1) % Side;
      nb[2] = ((r + 1) % Side) * Side + c;
      nb[3] = ((r + Side - 1) % Side) * Side + c;
      for (int n = 0; n < 4; n++) begin
        t = nb[n];
        if (spin_sh[t] == s && !mark_sh[t]) begin
          if ({1'b0, draw_bond()} < thr_sh && tail < Sites) begin
            spin_sh[t] = ~s;
            mark_sh[t] = 1'b1;
            walk_q[tail++] = t;
          end
        end
      end
    end
    for (k = 0; k < tail; k++) mark_sh[walk_q[k]] = 1'b0;
    ssum = 0;
    esum = 0;
    for (r = 0; r < Side; r++) begin
      for (c = 0; c < Side; c++) begin
        ssum += spin_sh[r*Side+c] ? 1 : -1;
        esum -= (spin_sh[r*Side+c] == spin_sh[r*Side+(c+1)%Side]) ? 1 : -1;
        esum -= (spin_sh[r*Side+c] == spin_sh[((r+1)%Side)*Side+c]) ? 1 : -1;
      end
    end
    res.cluster_size = tail[12:0];
    res.spin_sum = ssum[13:0];
    res.energy_sum = esum[14:0];
    return res;
  endfunction

  // Track accepted beats on every channel
  always @(posedge clk_i) begin
    flip_result_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegBondThreshold) thr_sh = cfg_data_i[16:0];
        else if (cfg_index_i == RegRngSeed) rng_sh = (cfg_data_i == 0) ? 32'd1 : cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_flips.push_back(flip_cluster(s_axis_tdata[5:0], s_axis_tdata[11:6]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[41:0];
        if (pending_flips.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = pending_flips.pop_front();
          if (typed_q.size() != 0) begin
            if (typed_q.pop_front()) want = typed_want_q.pop_front();
            else void'(typed_want_q.pop_front());
          end
          if (got.cluster_size != want.cluster_size || got.spin_sum != want.spin_sum ||
              got.energy_sum != want.energy_sum) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: size %0d/%0d spin %0d/%0d energy %0d/%0d (exp/act)",
                       want.cluster_size, got.cluster_size,
                       $signed(want.spin_sum), $signed(got.spin_sum),
                       $signed(want.energy_sum), $signed(got.energy_sum));
          end
        end
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic send_seed(logic [5:0] row, logic [5:0] col);
    while ($urandom_range(99) < tx_idle) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_flips.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  stim_row_t stim[$];

  function automatic stim_row_t seed_row(logic [5:0] r, logic [5:0] c, bit typed = 1'b0,
                                         int sz = 0, int ss = 0, int es = 0);
    stim_row_t e;
    e.kind = RowSeed;
    e.reg_idx = '0;
    e.reg_val = '0;
    e.row = r;
    e.col = c;
    e.typed = typed;
    e.want.cluster_size = sz[12:0];
    e.want.spin_sum = ss[13:0];
    e.want.energy_sum = es[14:0];
    return e;
  endfunction

  function automatic stim_row_t reg_row(logic [0:0] idx, logic [31:0] val);
    stim_row_t e;
    e = seed_row(6'd0, 6'd0);
    e.kind = RowReg;
    e.reg_idx = idx;
    e.reg_val = val;
    return e;
  endfunction

  initial begin
    rng_sh = 32'd1;
    thr_sh = '0;
    for (int i = 0; i < Sites; i++) begin
      spin_sh[i] = 1'b1;
      mark_sh[i] = 1'b0;
    end
    mismatches = 0;
    tx_idle = 0;
    rx_idle = 0;
    hold_cycles = 0;

    // Threshold zero after reset: single-site flips only
    stim.push_back(seed_row(6'd0, 6'd0, 1'b1, 1, 4094, -8184));
    stim.push_back(seed_row(6'd63, 6'd63, 1'b1, 1, 4092, -8176));
    stim.push_back(seed_row(6'd0, 6'd0, 1'b1, 1, 4094, -8184));
    stim.push_back(seed_row(6'd63, 6'd0));
    stim.push_back(seed_row(6'd0, 6'd63));
    // Full join and the zero seed
    stim.push_back(reg_row(RegBondThreshold, 32'd65536));
    stim.push_back(reg_row(RegRngSeed, 32'd0));
    stim.push_back(seed_row(6'd21, 6'd42));
    stim.push_back(seed_row(6'd42, 6'd21));
    // Threshold above full scale, all data bits set
    stim.push_back(reg_row(RegBondThreshold, 32'hFFFF_FFFF));
    stim.push_back(seed_row(6'd63, 6'd63));
    stim.push_back(reg_row(RegBondThreshold, 32'd32768));
    stim.push_back(reg_row(RegRngSeed, 32'hFFFF_FFFF));
    stim.push_back(seed_row(6'd0, 6'd0));
    stim.push_back(seed_row(6'd63, 6'd63));
    stim.push_back(seed_row(6'd1, 6'd62));
    stim.push_back(reg_row(RegBondThreshold, 32'd1));
    stim.push_back(reg_row(RegRngSeed, 32'h1234_5678));
    stim.push_back(seed_row(6'd10, 6'd50));
    stim.push_back(seed_row(6'd50, 6'd10));
    stim.push_back(reg_row(RegBondThreshold, 32'd65535));
    stim.push_back(seed_row(6'd32, 6'd32));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle = 35;
    rx_idle = 77;
    foreach (stim[i]) begin
      if (stim[i].kind == RowReg) begin
        wait_drained();
        write_reg(stim[i].reg_idx, stim[i].reg_val);
      end else begin
        typed_q.push_back(stim[i].typed);
        typed_want_q.push_back(stim[i].want);
        send_seed(stim[i].row, stim[i].col);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      tx_idle = (phase == 0) ? 35 : (phase == 1) ? 77 : 0;
      rx_idle = (phase == 0) ? 77 : (phase == 1) ? 35 : 0;
      // Mostly small clusters; now and then near the critical bond strength
      write_reg(RegBondThreshold, ($urandom_range(3) == 0) ? $urandom_range(36000, 40000)
                                                          : $urandom_range(0, 30000));
      write_reg(RegRngSeed, $urandom());
      for (int n = 0; n < 34; n++) begin
        if (phase == 0 && n == 5) hold_cycles = 30000;
        if (phase == 1 && n == 17) begin
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          while (pending_flips.size() != 0) @(posedge clk_i);
        end
        send_seed(6'($urandom_range(63)), 6'($urandom_range(63)));
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_flips.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_flips.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/iwcu_pkg.sv
sv/iwcu_rng.sv
sv/ising_wolff_cluster_update_top.sv
tb/tb_ising_wolff_cluster_update_top.sv
